[hdl/stl_pkg.sv]
// Shared definitions for the statement lexer: token kinds, lexer modes,
// character codes, keyword spellings and byte classification functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 4;
  localparam int MODE_W          = 3;
  localparam int WORD_W          = 24;
  localparam int DEF_OFFSET_BITS = 20;
  localparam int DEF_LENGTH_BITS = 12;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = 2;
  localparam int QCNT_W          = 3;

  localparam logic [MODE_W-1:0] M_IDLE = 3'd0;
  localparam logic [MODE_W-1:0] M_WORD = 3'd1;
  localparam logic [MODE_W-1:0] M_NUM  = 3'd2;
  localparam logic [MODE_W-1:0] M_EOL  = 3'd3;
  localparam logic [MODE_W-1:0] M_HALT = 3'd4;

  localparam logic [KIND_W-1:0] K_INT   = 4'd0;
  localparam logic [KIND_W-1:0] K_ID    = 4'd1;
  localparam logic [KIND_W-1:0] K_MUT   = 4'd2;
  localparam logic [KIND_W-1:0] K_TYPE  = 4'd3;
  localparam logic [KIND_W-1:0] K_END   = 4'd4;
  localparam logic [KIND_W-1:0] K_PLUS  = 4'd5;
  localparam logic [KIND_W-1:0] K_MINUS = 4'd6;
  localparam logic [KIND_W-1:0] K_DIV   = 4'd7;
  localparam logic [KIND_W-1:0] K_MUL   = 4'd8;
  localparam logic [KIND_W-1:0] K_COLON = 4'd9;
  localparam logic [KIND_W-1:0] K_EQUAL = 4'd10;
  localparam logic [KIND_W-1:0] K_EOF   = 4'd11;
  localparam logic [KIND_W-1:0] K_ERROR = 4'd12;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;

  localparam logic [WORD_W-1:0] WORD_CST = 24'h637374;
  localparam logic [WORD_W-1:0] WORD_VAR = 24'h766172;
  localparam logic [WORD_W-1:0] WORD_I32 = 24'h493332;

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

endpackage

`default_nettype wire

[hdl/stl_step.sv]
// Lexer state and the per-byte classification step: flushes a pending token
// and starts the next one, giving up to two packed result entries per byte.
// Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_step #(
  parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = stl_pkg::DEF_LENGTH_BITS,
  localparam int ENT_W = 1 + LENGTH_BITS + OFFSET_BITS + stl_pkg::KIND_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic [stl_pkg::BYTE_W-1:0]  byte_in,
  output logic [1:0]                       res_cnt,
  output logic [ENT_W-1:0]                 res0,
  output logic [ENT_W-1:0]                 res1
);

  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_THREE = LENGTH_BITS'(3);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;

  logic [stl_pkg::MODE_W-1:0] mode, mode_next;
  logic [OFFSET_BITS-1:0]     position, position_next;
  logic [OFFSET_BITS-1:0]     token_start, token_start_next;
  logic [LENGTH_BITS-1:0]     token_length, token_length_next;
  logic [stl_pkg::WORD_W-1:0] first_chars, first_chars_next;

  logic                       b_letter, b_digit, b_space, b_eol, b_zero;
  logic                       bg_emit, bg_load;
  logic [stl_pkg::KIND_W-1:0] bg_kind;
  logic [stl_pkg::MODE_W-1:0] bg_mode;
  logic [stl_pkg::KIND_W-1:0] fl_kind;
  logic                       pending, extend;
  logic                       do_flush, do_begin;
  logic                       sec_emit;
  logic [stl_pkg::KIND_W-1:0] sec_kind;
  logic [LENGTH_BITS-1:0]     sec_len;
  logic [ENT_W-1:0]           fl_ent, sec_ent;

  assign b_letter = stl_pkg::is_letter(byte_in);
  assign b_digit  = stl_pkg::is_digit(byte_in);
  assign b_space  = (byte_in == stl_pkg::CH_SPACE) || (byte_in == stl_pkg::CH_TAB);
  assign b_eol    = (byte_in == stl_pkg::CH_LF) || (byte_in == stl_pkg::CH_CR);
  assign b_zero   = (byte_in == stl_pkg::CH_NUL);
  assign pending  = (mode == stl_pkg::M_WORD) || (mode == stl_pkg::M_NUM);
  assign extend   = ((mode == stl_pkg::M_WORD) && (b_letter || b_digit)) ||
                    ((mode == stl_pkg::M_NUM) && b_digit);

  always_comb begin
    bg_emit = 1'b1;
    bg_load = 1'b0;
    bg_kind = stl_pkg::K_ERROR;
    bg_mode = stl_pkg::M_HALT;
    if (b_space) begin
      bg_emit = 1'b0;
      bg_mode = stl_pkg::M_IDLE;
    end else if (b_letter) begin
      bg_emit = 1'b0;
      bg_load = 1'b1;
      bg_mode = stl_pkg::M_WORD;
    end else if (b_digit) begin
      bg_emit = 1'b0;
      bg_load = 1'b1;
      bg_mode = stl_pkg::M_NUM;
    end else if (b_eol) begin
      bg_kind = stl_pkg::K_END;
      bg_mode = stl_pkg::M_EOL;
    end else begin
      bg_mode = stl_pkg::M_IDLE;
      case (byte_in)
        stl_pkg::CH_PLUS:  bg_kind = stl_pkg::K_PLUS;
        stl_pkg::CH_MINUS: bg_kind = stl_pkg::K_MINUS;
        stl_pkg::CH_SLASH: bg_kind = stl_pkg::K_DIV;
        stl_pkg::CH_STAR:  bg_kind = stl_pkg::K_MUL;
        stl_pkg::CH_COLON: bg_kind = stl_pkg::K_COLON;
        stl_pkg::CH_EQUAL: bg_kind = stl_pkg::K_EQUAL;
        default: begin
          bg_kind = stl_pkg::K_ERROR;
          bg_mode = stl_pkg::M_HALT;
        end
      endcase
    end
  end

  always_comb begin
    fl_kind = stl_pkg::K_INT;
    if (mode == stl_pkg::M_WORD) begin
      fl_kind = stl_pkg::K_ID;
      if (token_length == LEN_THREE) begin
        if ((first_chars == stl_pkg::WORD_CST) || (first_chars == stl_pkg::WORD_VAR)) begin
          fl_kind = stl_pkg::K_MUT;
        end else if (first_chars == stl_pkg::WORD_I32) begin
          fl_kind = stl_pkg::K_TYPE;
        end
      end
    end
  end

  always_comb begin
    mode_next         = mode;
    position_next     = position;
    token_start_next  = token_start;
    token_length_next = token_length;
    first_chars_next  = first_chars;
    do_flush          = 1'b0;
    do_begin          = 1'b0;
    sec_emit          = 1'b0;
    sec_kind          = stl_pkg::K_EOF;
    sec_len           = LEN_ZERO;
    if (b_zero) begin
      do_flush          = pending;
      sec_emit          = 1'b1;
      mode_next         = stl_pkg::M_IDLE;
      position_next     = '0;
      token_start_next  = '0;
      token_length_next = '0;
      first_chars_next  = '0;
    end else begin
      if (position != OFF_MAX) begin
        position_next = position + 1'b1;
      end
      case (mode)
        stl_pkg::M_HALT: begin
        end
        stl_pkg::M_WORD, stl_pkg::M_NUM: begin
          if (extend) begin
            if (token_length < LEN_THREE) begin
              first_chars_next = {first_chars[15:0], byte_in};
            end
            if (token_length != LEN_MAX) begin
              token_length_next = token_length + 1'b1;
            end
          end else begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        stl_pkg::M_EOL: begin
          do_begin = !b_eol;
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase
      if (do_begin) begin
        sec_emit  = bg_emit;
        sec_kind  = bg_kind;
        sec_len   = LEN_ONE;
        mode_next = bg_mode;
        if (bg_load) begin
          token_start_next  = position;
          token_length_next = LEN_ONE;
          first_chars_next  = {16'h0000, byte_in};
        end
      end
    end
  end

  assign fl_ent  = {!sec_emit, token_length, token_start, fl_kind};
  assign sec_ent = {1'b1, sec_len, position, sec_kind};

  always_comb begin
    if (do_flush) begin
      res0    = fl_ent;
      res1    = sec_ent;
      res_cnt = sec_emit ? 2'd2 : 2'd1;
    end else begin
      res0    = sec_ent;
      res1    = sec_ent;
      res_cnt = sec_emit ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= stl_pkg::M_IDLE;
      position     <= '0;
      token_start  <= '0;
      token_length <= '0;
      first_chars  <= '0;
    end else if (fire) begin
      mode         <= mode_next;
      position     <= position_next;
      token_start  <= token_start_next;
      token_length <= token_length_next;
      first_chars  <= first_chars_next;
    end
  end

endmodule

`default_nettype wire

[hdl/stl_out_queue.sv]
// Four-entry result queue that takes up to two entries per cycle and
// hands out one per cycle on a valid/ready output.
// Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_out_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [1:0]   wr_cnt,
  input  wire logic [W-1:0] wr_data0,
  input  wire logic [W-1:0] wr_data1,
  output logic              room2,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);

  logic [W-1:0]               entries [stl_pkg::QDEPTH];
  logic [stl_pkg::QPTR_W-1:0] wptr, rptr;
  logic [stl_pkg::QCNT_W-1:0] count;
  logic                       rd_fire;

  assign rd_valid = (count != '0);
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_data  = entries[rptr];
  assign room2    = (count <= stl_pkg::QCNT_W'(stl_pkg::QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      entries[wptr] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      entries[stl_pkg::QPTR_W'(wptr + 1'b1)] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= stl_pkg::QPTR_W'(wptr + wr_cnt);
      rptr  <= stl_pkg::QPTR_W'(rptr + rd_fire);
      count <= stl_pkg::QCNT_W'(count + wr_cnt - rd_fire);
    end
  end

endmodule

`default_nettype wire

[hdl/statement_lexer_core.sv]
// Top level of the statement lexer: input register, lexer step and result queue.
// Depends on stl_pkg, stl_step and stl_out_queue.
//
// Usage: source bytes enter on the s_* stream, one item per byte; a zero byte
// ends the source and restarts the offset count at zero. Tokens leave on the
// m_* stream as kind, start offset and length, with m_tlast set on the final
// token caused by one input byte. A byte may cause no token, one or two.
// The input register takes the byte when it is accepted, and the step logic
// writes its tokens into the queue once the queue has room for two tokens;
// the queue then offers them to the receiver from its registered entries.
// Throughput is one byte per cycle while the receiver takes tokens at least
// as fast as they are made; the two tokens of one byte leave one at a time,
// set by the single read port of the four-entry result queue.
// The step logic takes a byte only when the queue has room for two tokens.
// When the receiver stalls, the queue fills and s_tready drops; nothing is
// lost. Reset (rst, synchronous) empties the queue and input register and
// returns the lexer to idle at offset zero.
`timescale 1ns / 1ps
`default_nettype none

module statement_lexer_core #(
  parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = stl_pkg::DEF_LENGTH_BITS,
  localparam int OUT_W = ((stl_pkg::KIND_W + OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [stl_pkg::BYTE_W-1:0] s_tdata,   // byte_req
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [OUT_W-1:0]                m_tdata,   // kind, start_offset, length, zero fill
  output logic                            m_tlast    // last_of_run
);

  localparam int ENT_W = 1 + LENGTH_BITS + OFFSET_BITS + stl_pkg::KIND_W;

  logic                       in_valid;
  logic [stl_pkg::BYTE_W-1:0] in_byte;
  logic                       room2, fire;
  logic [1:0]                 res_cnt, wr_cnt;
  logic [ENT_W-1:0]           res0, res1, rd_data;

  assign fire     = in_valid && room2;
  assign s_tready = !in_valid || fire;
  assign wr_cnt   = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  stl_step #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .byte_in(in_byte),
    .res_cnt(res_cnt),
    .res0   (res0),
    .res1   (res1)
  );

  stl_out_queue #(
    .W(ENT_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_cnt  (wr_cnt),
    .wr_data0(res0),
    .wr_data1(res1),
    .room2   (room2),
    .rd_valid(m_tvalid),
    .rd_ready(m_tready),
    .rd_data (rd_data)
  );

  assign m_tdata = OUT_W'(rd_data[ENT_W-2:0]);
  assign m_tlast = rd_data[ENT_W-1];

endmodule

`default_nettype wire

[hdl/stl_checker.sv]
// Port-level assertions for statement_lexer_core and the bind that attaches them.
// Depends on stl_pkg and statement_lexer_core.
`timescale 1ns / 1ps
`default_nettype none

module stl_checker #(
  parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS,
  parameter int LENGTH_BITS = stl_pkg::DEF_LENGTH_BITS,
  localparam int OUT_W = ((stl_pkg::KIND_W + OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic             m_tlast
);

  localparam int LEN_LO = stl_pkg::KIND_W + OFFSET_BITS;

  logic [stl_pkg::KIND_W-1:0] kind;
  logic [LENGTH_BITS-1:0]     len;
  logic                       single;

  assign kind   = m_tdata[stl_pkg::KIND_W-1:0];
  assign len    = m_tdata[LEN_LO+LENGTH_BITS-1:LEN_LO];
  assign single = (kind == stl_pkg::K_END) || (kind == stl_pkg::K_ERROR) ||
                  (kind == stl_pkg::K_PLUS) || (kind == stl_pkg::K_MINUS) ||
                  (kind == stl_pkg::K_DIV) || (kind == stl_pkg::K_MUL) ||
                  (kind == stl_pkg::K_COLON) || (kind == stl_pkg::K_EQUAL);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled output item changed.");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid right after reset.");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (kind == stl_pkg::K_EOF) |-> m_tlast && (len == '0))
    else $error("End-of-source item without tlast or with nonzero length.");

  a_single_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && single |-> (len == LENGTH_BITS'(1)) && m_tlast)
    else $error("Single-character item with wrong length or tlast.");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (kind <= stl_pkg::K_ERROR))
    else $error("Output kind out of range.");

endmodule

bind statement_lexer_core stl_checker #(
  .OFFSET_BITS(OFFSET_BITS),
  .LENGTH_BITS(LENGTH_BITS)
) u_stl_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

`default_nettype wire

[bench/statement_lexer_core_tb.sv]
// Self-checking testbench for statement_lexer_core: drives source bytes and checks every
// token against a behavioral lexer kept in step with the accepted bytes or against the directed table.
// Depends on stl_pkg and the statement_lexer_core RTL.
`timescale 1ns / 1ps

module statement_lexer_core_tb;

  localparam int BYTE_W = stl_pkg::BYTE_W;
  localparam int KIND_W = stl_pkg::KIND_W;
  localparam int OFF_W  = stl_pkg::DEF_OFFSET_BITS;
  localparam int LEN_W  = stl_pkg::DEF_LENGTH_BITS;
  localparam int TOK_W  = KIND_W + OFF_W + LEN_W;
  localparam int OUT_W  = ((TOK_W + 7) / 8) * 8;
  localparam int N_ROWS = 25;

  typedef struct packed {
    logic             last;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] start;
    logic [KIND_W-1:0] kind;
  } tok_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
  } row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;

  tok_t              tok_expected[$];
  tok_t              lex_batch[$];
  logic [BYTE_W-1:0] src_q[$];
  int                mism_count = 0;
  int                tok_seen = 0;
  bit                quiet_src = 1'b0;

  logic [stl_pkg::MODE_W-1:0] lx_mode;
  logic [OFF_W-1:0]           lx_pos;
  logic [OFF_W-1:0]           lx_start;
  logic [LEN_W-1:0]           lx_len;
  logic [stl_pkg::WORD_W-1:0] lx_word;

  logic [BYTE_W-1:0] op_chars[6] = '{stl_pkg::CH_PLUS, stl_pkg::CH_MINUS, stl_pkg::CH_SLASH,
                                     stl_pkg::CH_STAR, stl_pkg::CH_COLON, stl_pkg::CH_EQUAL};

  row_t dir_rows[N_ROWS] = '{
    '{stl_pkg::CH_PLUS,  1'b1, stl_pkg::K_PLUS,  20'd0,  12'd1},
    '{stl_pkg::CH_MINUS, 1'b1, stl_pkg::K_MINUS, 20'd1,  12'd1},
    '{stl_pkg::CH_SLASH, 1'b1, stl_pkg::K_DIV,   20'd2,  12'd1},
    '{stl_pkg::CH_STAR,  1'b1, stl_pkg::K_MUL,   20'd3,  12'd1},
    '{"c",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"s",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"t",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_SPACE, 1'b1, stl_pkg::K_MUT,   20'd4,  12'd3},
    '{"v",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"a",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"r",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_COLON, 1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"I",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"3",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"2",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_LF,    1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_CR,    1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"9",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{"x",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_EQUAL, 1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_TAB,   1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_NUL,   1'b1, stl_pkg::K_EOF,   20'd21, 12'd0},
    '{8'hFF,             1'b1, stl_pkg::K_ERROR, 20'd0,  12'd1},
    '{"a",               1'b0, stl_pkg::K_INT,   20'd0,  12'd0},
    '{stl_pkg::CH_NUL,   1'b1, stl_pkg::K_EOF,   20'd2,  12'd0}
  };

  statement_lexer_core #(
    .OFFSET_BITS(OFF_W),
    .LENGTH_BITS(LEN_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_alpha(input logic [BYTE_W-1:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_num(input logic [BYTE_W-1:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [BYTE_W-1:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("A" + $urandom_range(0, 25))
                                : 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
  endfunction

  task automatic lex_reset();
    lx_mode  = stl_pkg::M_IDLE;
    lx_pos   = '0;
    lx_start = '0;
    lx_len   = '0;
    lx_word  = '0;
  endtask

  task automatic lex_emit(input logic [KIND_W-1:0] k, input logic [OFF_W-1:0] st,
                          input logic [LEN_W-1:0] ln);
    lex_batch.push_back(tok_t'{last: 1'b0, len: ln, start: st, kind: k});
  endtask

  task automatic lex_flush();
    logic [KIND_W-1:0] k;
    k = (lx_mode == stl_pkg::M_NUM) ? stl_pkg::K_INT : stl_pkg::K_ID;
    if (lx_mode == stl_pkg::M_WORD && lx_len == 3) begin
      if (lx_word == stl_pkg::WORD_CST || lx_word == stl_pkg::WORD_VAR) k = stl_pkg::K_MUT;
      else if (lx_word == stl_pkg::WORD_I32) k = stl_pkg::K_TYPE;
    end
    if (lx_mode == stl_pkg::M_NUM || lx_mode == stl_pkg::M_WORD) begin
      lx_mode = stl_pkg::M_IDLE;
      lex_emit(k, lx_start, lx_len);
    end
  endtask

  task automatic lex_begin(input logic [BYTE_W-1:0] b);
    if (b == stl_pkg::CH_SPACE || b == stl_pkg::CH_TAB) begin
      lx_mode = stl_pkg::M_IDLE;
    end else if (is_alpha(b) || is_num(b)) begin
      lx_mode  = is_alpha(b) ? stl_pkg::M_WORD : stl_pkg::M_NUM;
      lx_start = lx_pos;
      lx_len   = 1;
      lx_word  = {16'h0000, b};
    end else if (b == stl_pkg::CH_LF || b == stl_pkg::CH_CR) begin
      lx_mode = stl_pkg::M_EOL;
      lex_emit(stl_pkg::K_END, lx_pos, 1);
    end else begin
      lx_mode = stl_pkg::M_IDLE;
      case (b)
        stl_pkg::CH_PLUS:  lex_emit(stl_pkg::K_PLUS, lx_pos, 1);
        stl_pkg::CH_MINUS: lex_emit(stl_pkg::K_MINUS, lx_pos, 1);
        stl_pkg::CH_SLASH: lex_emit(stl_pkg::K_DIV, lx_pos, 1);
        stl_pkg::CH_STAR:  lex_emit(stl_pkg::K_MUL, lx_pos, 1);
        stl_pkg::CH_COLON: lex_emit(stl_pkg::K_COLON, lx_pos, 1);
        stl_pkg::CH_EQUAL: lex_emit(stl_pkg::K_EQUAL, lx_pos, 1);
        default: begin
          lx_mode = stl_pkg::M_HALT;
          lex_emit(stl_pkg::K_ERROR, lx_pos, 1);
        end
      endcase
    end
  endtask

  task automatic lex_predict(input logic [BYTE_W-1:0] b, input bit keep);
    lex_batch.delete();
    if (b == stl_pkg::CH_NUL) begin
      lex_flush();
      lex_emit(stl_pkg::K_EOF, lx_pos, 0);
      lex_reset();
    end else begin
      case (lx_mode)
        stl_pkg::M_HALT: ;
        stl_pkg::M_WORD, stl_pkg::M_NUM: begin
          if ((lx_mode == stl_pkg::M_WORD && (is_alpha(b) || is_num(b))) ||
              (lx_mode == stl_pkg::M_NUM && is_num(b))) begin
            if (lx_len < 3) lx_word = {lx_word[15:0], b};
            if (lx_len != '1) lx_len = lx_len + 1'b1;
          end else begin
            lex_flush();
            lex_begin(b);
          end
        end
        stl_pkg::M_EOL: begin
          if (b != stl_pkg::CH_LF && b != stl_pkg::CH_CR) lex_begin(b);
        end
        default: lex_begin(b);
      endcase
      if (lx_pos != '1) lx_pos = lx_pos + 1'b1;
    end
    if (lex_batch.size() > 0) lex_batch[lex_batch.size() - 1].last = 1'b1;
    if (keep) begin
      foreach (lex_batch[i]) tok_expected.push_back(lex_batch[i]);
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = quiet_src ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic build_source();
    int                         n_tok;
    int                         pick;
    logic [stl_pkg::WORD_W-1:0] kw;
    src_q.delete();
    n_tok = $urandom_range(0, 14);
    repeat (n_tok) begin
      pick = $urandom_range(0, 7);
      kw = (pick % 3 == 0) ? stl_pkg::WORD_CST :
           (pick % 3 == 1) ? stl_pkg::WORD_VAR : stl_pkg::WORD_I32;
      case ($urandom_range(0, 9))
        0, 1: begin
          if (pick < 3) begin
            src_q.push_back(kw[23:16]);
            src_q.push_back(kw[15:8]);
            src_q.push_back(kw[7:0]);
            if ($urandom_range(0, 3) == 0) src_q.push_back(rand_alnum());
          end else begin
            src_q.push_back(rand_letter());
            repeat ($urandom_range(0, 5)) src_q.push_back(rand_alnum());
          end
        end
        2, 3: repeat ($urandom_range(1, 5)) src_q.push_back(8'("0" + $urandom_range(0, 9)));
        4: src_q.push_back(op_chars[$urandom_range(0, 5)]);
        5, 6: repeat ($urandom_range(1, 3))
          src_q.push_back($urandom_range(0, 1) ? stl_pkg::CH_SPACE : stl_pkg::CH_TAB);
        7: repeat ($urandom_range(1, 3))
          src_q.push_back($urandom_range(0, 1) ? stl_pkg::CH_CR : stl_pkg::CH_LF);
        8: src_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
                                                       : stl_pkg::CH_SPACE);
        default: begin
          src_q.push_back(kw[23:16]);
          src_q.push_back(kw[15:8]);
        end
      endcase
    end
    src_q.push_back(stl_pkg::CH_NUL);
  endtask

  task automatic check_token();
    tok_t              want;
    logic [KIND_W-1:0] k;
    logic [OFF_W-1:0]  st;
    logic [LEN_W-1:0]  ln;
    logic [OUT_W-TOK_W-1:0] fill;
    k    = m_tdata[KIND_W-1:0];
    st   = m_tdata[KIND_W +: OFF_W];
    ln   = m_tdata[KIND_W + OFF_W +: LEN_W];
    fill = m_tdata[OUT_W-1:TOK_W];
    if (tok_expected.size() == 0) begin
      mism_count++;
      if (mism_count <= 10)
        $display("Unexpected token: kind %0d start %0d len %0d last %0b", k, st, ln, m_tlast);
    end else begin
      want = tok_expected.pop_front();
      if (k !== want.kind || st !== want.start || ln !== want.len ||
          m_tlast !== want.last || fill !== '0) begin
        mism_count++;
        if (mism_count <= 10)
          $display({"Token mismatch: expected kind %0d start %0d len %0d last %0b, ",
                    "got kind %0d start %0d len %0d last %0b fill %0h"},
                   want.kind, want.start, want.len, want.last, k, st, ln, m_tlast, fill);
      end
    end
  endtask

  initial begin : receiver
    int gap;
    int quiet_left;
    m_tready   = 1'b0;
    quiet_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (tok_seen == 40 || tok_seen == 700) begin
        gap = 300;
      end else if (quiet_left > 0) begin
        gap = 0;
        quiet_left--;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 19) == 0) quiet_left = 30;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_token();
      tok_seen++;
    end
  end

  initial begin : sender
    int rand_sent;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    rand_sent = 0;
    lex_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      send_byte(dir_rows[i].b);
      lex_predict(dir_rows[i].b, !dir_rows[i].typed);
      if (dir_rows[i].typed)
        tok_expected.push_back(tok_t'{last: 1'b1, len: dir_rows[i].len,
                                      start: dir_rows[i].start, kind: dir_rows[i].kind});
    end

    while (rand_sent < 1400) begin
      quiet_src = ($urandom_range(0, 3) == 0);
      build_source();
      foreach (src_q[i]) begin
        send_byte(src_q[i]);
        lex_predict(src_q[i], 1'b1);
        rand_sent++;
      end
    end
    s_tvalid <= 1'b0;

    while (tok_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mism_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
